### rtl/core/ppq_pkg.sv
// Shared types, constants and key-compare functions for the process priority queue.
package ppq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int ID_W      = 8;
	localparam int TIME_W    = 16;
	localparam int PRIO_W    = 8;
	localparam int COUNT_W   = 5;

	// Ordering policy codes
	localparam logic POLICY_SRTF = 1'b0;
	localparam logic POLICY_PRIO = 1'b1;

	// Operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]   pid;
		logic [TIME_W-1:0] rtime;
		logic [PRIO_W-1:0] prio;
	} ppq_entry_t;

	// Stored entry key is equal to or better than the new key
	function automatic logic slot_not_worse(input logic pol, input ppq_entry_t slot,
		input ppq_entry_t nw);
		logic res;
		if (pol == POLICY_PRIO) begin
			res = (slot.prio >= nw.prio);
		end else begin
			res = (slot.rtime <= nw.rtime);
		end
		return res;
	endfunction

	// New key is strictly better than the stored entry key
	function automatic logic new_better(input logic pol, input ppq_entry_t slot,
		input ppq_entry_t nw);
		logic res;
		if (pol == POLICY_PRIO) begin
			res = (nw.prio > slot.prio);
		end else begin
			res = (nw.rtime < slot.rtime);
		end
		return res;
	endfunction

endpackage

### rtl/core/process_priority_queue.sv
// Sorted process queue: entry memory, insert/remove walk sequencer and result register.
// Insert walks the memory from the new entry's position, then writes the tail entry and the
//   result; remove shifts entries toward the head; a refused insert goes straight to the result.
// Throughput: one item at a time, bounded by the one-entry-per-cycle memory walk; the next
//   item is taken while the result waits downstream.
// Reset: arst_n clears the fill count, policy (to shortest remaining time first) and the
//   handshake state; the entry memory is not cleared, only entries below the count are read.
module process_priority_queue #(
	parameter int DEPTH = ppq_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// item input
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic [ppq_pkg::ID_W-1:0]    process_id,
	input  logic [ppq_pkg::TIME_W-1:0]  remaining_time,
	input  logic [ppq_pkg::PRIO_W-1:0]  priority_req,
	// policy register write
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        policy,
	// result output
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        ok,
	output logic [ppq_pkg::ID_W-1:0]    out_process_id,
	output logic [ppq_pkg::TIME_W-1:0]  out_remaining_time,
	output logic [ppq_pkg::PRIO_W-1:0]  out_priority,
	output logic                        head_valid,
	output logic [ppq_pkg::ID_W-1:0]    head_process_id,
	output logic [ppq_pkg::TIME_W-1:0]  head_remaining_time,
	output logic [ppq_pkg::PRIO_W-1:0]  head_priority,
	output logic [ppq_pkg::COUNT_W-1:0] entry_count
);
	import ppq_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [4:0] {
		S_IDLE     = 5'b00001,
		S_INS_WALK = 5'b00010,
		S_INS_TAIL = 5'b00100,
		S_RM_WALK  = 5'b01000,
		S_RESP     = 5'b10000
	} state_t;

	state_t     state_q;
	logic       policy_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] idx_nxt;
	logic       found_q;
	logic       force_q;
	ppq_entry_t new_q;
	ppq_entry_t carry_q;
	ppq_entry_t head_q;
	ppq_entry_t rem_q;
	logic       ok_q;

	// entry memory ports
	ppq_entry_t mem [DEPTH];
	logic          mem_we;
	logic [IW-1:0] mem_wa;
	ppq_entry_t    mem_wd;
	logic [IW-1:0] mem_ra;
	ppq_entry_t    mem_rd;

	// result register
	logic       out_valid_q;
	logic       ok_o_q;
	ppq_entry_t rem_o_q;
	ppq_entry_t head_o_q;
	logic       head_valid_o_q;
	logic [CW-1:0] count_o_q;

	ppq_entry_t in_entry;
	logic       accept;
	logic       ins_force;
	logic       ins_place;
	logic       resp_load;

	assign in_entry  = '{pid: process_id, rtime: remaining_time, prio: priority_req};
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign idx_nxt   = idx_q + 1'b1;
	assign resp_load = (state_q == S_RESP) && (!out_valid_q || !out_stall);

	// new entry goes to the head: empty queue or strictly better than the current head
	assign ins_force = (count_q == '0) || new_better(policy_q, head_q, in_entry);
	// in the walk, the first stored entry worse than the new one gives up its slot
	assign ins_place = !found_q && (force_q || !slot_not_worse(policy_q, mem_rd, new_q));

	// memory read address and write port
	always_comb begin
		mem_ra = idx_nxt[IW-1:0];
		mem_we = 1'b0;
		mem_wa = idx_q[IW-1:0];
		mem_wd = new_q;
		case (state_q)
			S_IDLE: begin
				if (mode == OP_REMOVE) begin
					mem_ra = IW'(1);
				end else if (ins_force) begin
					mem_ra = '0;
				end else begin
					mem_ra = IW'(1);
				end
			end
			S_INS_WALK: begin
				if (found_q) begin
					mem_we = 1'b1;
					mem_wd = carry_q;
				end else if (ins_place) begin
					mem_we = 1'b1;
					mem_wd = new_q;
				end
			end
			S_INS_TAIL: begin
				mem_we = 1'b1;
				mem_wa = count_q[IW-1:0];
				mem_wd = found_q ? carry_q : new_q;
			end
			S_RM_WALK: begin
				mem_we = 1'b1;
				mem_wa = IW'(idx_q - 1'b1);
				mem_wd = mem_rd;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		mem_rd <= mem[mem_ra];
	end

	// policy register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POLICY_SRTF;
		end else if (cfg_valid && cfg_ready) begin
			policy_q <= policy;
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (mode == OP_INSERT) begin
							if (count_q == CW'(DEPTH)) begin
								state_q <= S_RESP;
							end else if (count_q == '0 || (!ins_force && count_q == CW'(1))) begin
								// empty, or placed after the lone head entry: no walk needed
								state_q <= S_INS_TAIL;
							end else begin
								state_q <= S_INS_WALK;
							end
						end else begin
							if (count_q <= CW'(1)) begin
								state_q <= S_RESP;
								count_q <= '0;
							end else begin
								state_q <= S_RM_WALK;
							end
						end
					end
				end
				S_INS_WALK: begin
					if (idx_nxt == count_q) begin
						state_q <= S_INS_TAIL;
					end
				end
				S_INS_TAIL: begin
					count_q <= count_q + 1'b1;
					state_q <= S_RESP;
				end
				S_RM_WALK: begin
					if (idx_nxt == count_q) begin
						count_q <= count_q - 1'b1;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (resp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// walk datapath: index, carried entry, head copy and result fields
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					new_q   <= in_entry;
					found_q <= 1'b0;
					force_q <= ins_force;
					if (mode == OP_INSERT) begin
						idx_q <= ins_force ? '0 : CW'(1);
						ok_q  <= (count_q != CW'(DEPTH));
						rem_q <= '0;
					end else begin
						idx_q <= CW'(1);
						ok_q  <= (count_q != '0);
						rem_q <= (count_q != '0) ? head_q : '0;
					end
				end
			end
			S_INS_WALK: begin
				idx_q <= idx_nxt;
				if (found_q || ins_place) begin
					carry_q <= mem_rd;
					found_q <= 1'b1;
				end
			end
			S_INS_TAIL: begin
				if (force_q) begin
					head_q <= new_q;
				end
			end
			S_RM_WALK: begin
				idx_q <= idx_nxt;
				if (idx_q == CW'(1)) begin
					head_q <= mem_rd;
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (resp_load) begin
			ok_o_q         <= ok_q;
			rem_o_q        <= rem_q;
			head_valid_o_q <= (count_q != '0);
			head_o_q       <= (count_q != '0) ? head_q : '0;
			count_o_q      <= count_q;
		end
	end

	assign out_valid           = out_valid_q;
	assign ok                  = ok_o_q;
	assign out_process_id      = rem_o_q.pid;
	assign out_remaining_time  = rem_o_q.rtime;
	assign out_priority        = rem_o_q.prio;
	assign head_valid          = head_valid_o_q;
	assign head_process_id     = head_o_q.pid;
	assign head_remaining_time = head_o_q.rtime;
	assign head_priority       = head_o_q.prio;
	assign entry_count         = COUNT_W'(count_o_q);

endmodule

### rtl/core/ppq_chk.sv
// Port-level checker for the process priority queue, bound to the top level.
module ppq_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        ok,
	input logic [ppq_pkg::ID_W-1:0]    out_process_id,
	input logic [ppq_pkg::TIME_W-1:0]  out_remaining_time,
	input logic [ppq_pkg::PRIO_W-1:0]  out_priority,
	input logic                        head_valid,
	input logic [ppq_pkg::ID_W-1:0]    head_process_id,
	input logic [ppq_pkg::TIME_W-1:0]  head_remaining_time,
	input logic [ppq_pkg::PRIO_W-1:0]  head_priority,
	input logic [ppq_pkg::COUNT_W-1:0] entry_count
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ok) && $stable(entry_count)
			&& $stable(head_process_id) && $stable(out_process_id))
		else $error("stalled result changed");

	// one item at a time: busy right after an accepted item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted while previous one in flight");

	// failed operation reports no removed entry
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> out_process_id == '0 && out_remaining_time == '0
			&& out_priority == '0)
		else $error("failed operation returned an entry");

	// empty queue shows a zero head
	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !head_valid |-> head_process_id == '0 && head_remaining_time == '0
			&& head_priority == '0 && entry_count == '0)
		else $error("empty queue with nonzero head");

endmodule

bind process_priority_queue ppq_chk u_ppq_chk (.*);
